// ===== rtl/core/aae_pkg.sv =====
package aae_pkg;

   localparam logic [1:0] KIND_ENCODE = 2'd0;
   localparam logic [1:0] KIND_END    = 2'd1;
   localparam logic [1:0] KIND_LOAD   = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [8:0]  symbol;
      logic [13:0] count;
   } req_type;

   typedef struct packed {
      logic        first_bit;
      logic [15:0] follow_count;
      logic        last;
   } rsp_type;

endpackage

// ===== rtl/core/aae_div.sv =====
module aae_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CW-1:0]    n_ff, n_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   sh;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      n_in = n_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sh = '0;
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         n_in = CW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
         q_in = {q_ff[NUM_W-2:0], 1'b0};
         if (sh >= {1'b0, d_ff}) begin
            r_in = sh - {1'b0, d_ff};
            q_in[0] = 1'b1;
         end else begin
            r_in = sh;
         end
         n_in = n_ff - 1'b1;
         if (n_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      n_ff <= n_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

// ===== rtl/core/adaptive_arithmetic_encoder.sv =====
// channel | dir | handshake             | payload
// req     | in  | req_valid/req_ready   | kind, symbol, count
// rsp     | out | rsp_valid/rsp_ready   | first_bit, follow_count, last
// csr     | in  | csr_valid/csr_ready   | model_mode
// after reset the cumulative table is rewritten, ALPHABET+2 entries, no beat taken
// an encode reads two entries, then runs two serial divisions, then, when model_mode is 0,
// bumps every entry above the symbol and halves the counts once the total reaches TOTAL_LIMIT
// a load rewrites the entries above its symbol; an end beat adds the ALPHABET+2 entry sweep
// each code bit or straddle step is one emit pass; a beat that may still be last is held back
module adaptive_arithmetic_encoder #(
   parameter int CODE_BITS   = 16,
   parameter int ALPHABET    = 256,
   parameter int TOTAL_LIMIT = 16384
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  aae_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output aae_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);
   import aae_pkg::*;

   localparam int DEPTH = ALPHABET + 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int TW    = $clog2(TOTAL_LIMIT + 1) + 1;
   localparam int NW    = TW + CODE_BITS + 1;
   localparam int FW    = 16;
   localparam logic [TW-1:0] LIMIT = TW'(TOTAL_LIMIT);

   localparam logic [4:0] S_INIT = 5'd0,  S_IDLE = 5'd1,  S_RD0 = 5'd2,  S_RD1 = 5'd3,
                          S_RD2 = 5'd4,  S_DIVU = 5'd5, S_DIVL = 5'd6, S_BUMP = 5'd7,
                          S_HRD = 5'd8,  S_HWR = 5'd9,  S_EMIT = 5'd10, S_LRD = 5'd11,
                          S_LWR = 5'd12, S_LEND = 5'd13, S_FIN = 5'd14, S_BRD = 5'd15,
                          S_WAITU = 5'd16, S_WAITL = 5'd17;

   logic [TW-1:0] mem [DEPTH];
   logic [TW-1:0] rd_ff;
   logic [AW-1:0] ra, wa;
   logic          we;
   logic [TW-1:0] wd;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   logic [4:0]           st_ff, st_in;
   logic                 mode_ff, mode_in;
   logic [CODE_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [FW-1:0]        pend_ff, pend_in;
   logic [TW-1:0]        tot_ff, tot_in;
   logic [AW:0]          idx_ff, idx_in;
   logic [8:0]           sym_ff, sym_in;
   logic [1:0]           kind_ff, kind_in;
   logic [13:0]          cnt_ff, cnt_in;
   logic [TW-1:0]        lob_ff, lob_in, upb_ff, upb_in;
   logic [TW-1:0]        prev_ff, prev_in, acc_ff, acc_in, base_ff, base_in;
   logic [CODE_BITS:0]   rng_ff, rng_in;
   logic [NW-1:0]        upq_ff, upq_in;
   logic                 vld_ff, vld_in;
   rsp_type              out_ff, out_in;

   logic          dstart, ddone;
   logic [NW-1:0] dnum, dquot;
   logic [NW-1:0] prod;

   assign prod = NW'(((st_ff == S_RD2) ? upb_ff : lob_ff)) * NW'(rng_ff);
   assign dnum = prod;

   aae_div #(.NUM_W(NW), .DEN_W(TW)) u_div (
      .clock(clock), .reset(reset), .start(dstart), .num(dnum),
      .den((tot_ff == '0) ? TW'(1) : tot_ff), .done(ddone), .quot(dquot));

   localparam logic [CODE_BITS-1:0] TOP  = CODE_BITS'(1) << (CODE_BITS - 1);
   localparam logic [CODE_BITS-1:0] NEXT = CODE_BITS'(1) << (CODE_BITS - 2);

   logic [TW-1:0] d, stp, v;
   logic [TW:0]   e;

   always_comb begin
      st_in = st_ff; mode_in = mode_ff; lo_in = lo_ff; hi_in = hi_ff;
      pend_in = pend_ff; tot_in = tot_ff; idx_in = idx_ff; sym_in = sym_ff;
      kind_in = kind_ff; cnt_in = cnt_ff; lob_in = lob_ff; upb_in = upb_ff;
      prev_in = prev_ff; acc_in = acc_ff; base_in = base_ff; rng_in = rng_ff;
      upq_in = upq_ff;
      vld_in = vld_ff; out_in = out_ff;
      ra = idx_ff[AW-1:0]; wa = idx_ff[AW-1:0]; we = 1'b0; wd = '0;
      dstart = 1'b0; d = '0; stp = '0; v = '0; e = '0;
      if (rsp_valid && rsp_ready) vld_in = 1'b0;
      if (csr_valid) mode_in = csr_data;
      case (st_ff)
         S_INIT: begin
            we = 1'b1; wd = TW'(idx_ff);
            if (idx_ff == (AW+1)'(DEPTH - 1)) begin
               st_in = S_IDLE;
               tot_in = TW'(ALPHABET + 1);
               lo_in = '0; hi_in = '1; pend_in = '0;
            end else idx_in = idx_ff + 1'b1;
         end
         S_IDLE: begin
            if (req_valid) begin
               kind_in = req_data.kind; sym_in = req_data.symbol; cnt_in = req_data.count;
               case (req_data.kind)
                  KIND_ENCODE: if (32'(req_data.symbol) < ALPHABET) begin
                     idx_in = (AW+1)'(req_data.symbol); st_in = S_RD0;
                  end
                  KIND_END: begin
                     sym_in = 9'(ALPHABET); idx_in = (AW+1)'(ALPHABET); st_in = S_RD0;
                  end
                  KIND_LOAD: if (32'(req_data.symbol) <= ALPHABET) begin
                     idx_in = (AW+1)'(req_data.symbol); st_in = S_LRD;
                  end
                  default: ;
               endcase
            end
         end
         S_RD0: begin
            ra = idx_ff[AW-1:0]; idx_in = idx_ff + 1'b1; st_in = S_RD1;
            rng_in = {1'b0, hi_ff - lo_ff} + 1'b1;
         end
         S_RD1: begin
            ra = idx_ff[AW-1:0]; lob_in = rd_ff; st_in = S_BRD;
         end
         S_BRD: begin
            upb_in = rd_ff; st_in = S_RD2;
         end
         S_RD2: begin
            dstart = 1'b1; st_in = S_WAITU;
         end
         S_WAITU: if (ddone) begin
            upq_in = dquot; dstart = 1'b1; st_in = S_WAITL;
         end
         S_WAITL: if (ddone) begin
            hi_in = CODE_BITS'(NW'(lo_ff) + upq_ff - 1'b1);
            lo_in = CODE_BITS'(NW'(lo_ff) + dquot);
            if (!mode_ff) begin
               tot_in = tot_ff + 1'b1; st_in = S_BUMP;
            end else st_in = S_EMIT;
         end
         S_BUMP: begin
            ra = idx_ff[AW-1:0];
            if (idx_ff == (AW+1)'(DEPTH)) begin
               if (tot_ff >= LIMIT) begin
                  idx_in = (AW+1)'(1); prev_in = '0; acc_in = '0; base_in = '0;
                  st_in = S_HRD;
               end else st_in = S_EMIT;
            end else begin
               st_in = S_DIVU;
            end
         end
         S_DIVU: begin
            we = 1'b1; wd = rd_ff + 1'b1; idx_in = idx_ff + 1'b1;
            ra = AW'(idx_ff + 1'b1); st_in = S_BUMP;
         end
         S_HRD: begin
            ra = idx_ff[AW-1:0]; st_in = S_HWR;
         end
         S_HWR: begin
            d = (rd_ff >= prev_ff) ? rd_ff - prev_ff : '0;
            stp = (d <= TW'(2)) ? TW'(1) : (d >> 1);
            prev_in = rd_ff;
            we = 1'b1; wd = base_ff + stp; base_in = base_ff + stp;
            acc_in = acc_ff + stp;
            if (idx_ff == (AW+1)'(DEPTH - 1)) begin
               tot_in = acc_ff + stp; st_in = S_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1; st_in = S_HRD;
            end
         end
         S_EMIT: begin
            if ((hi_ff & TOP) == (lo_ff & TOP)) begin
               if (!vld_ff || rsp_ready) begin
                  vld_in = 1'b1;
                  out_in.first_bit = hi_ff[CODE_BITS-1];
                  out_in.follow_count = pend_ff;
                  out_in.last = 1'b0;
                  pend_in = '0;
                  lo_in = lo_ff << 1; hi_in = (hi_ff << 1) | CODE_BITS'(1);
               end
            end else if ((lo_ff & NEXT) != '0 && (hi_ff & NEXT) == '0) begin
               if (pend_ff != '1) pend_in = pend_ff + 1'b1;
               lo_in = (lo_ff & ~(TOP | NEXT)) << 1;
               hi_in = ((hi_ff | NEXT) << 1) | CODE_BITS'(1);
            end else if (kind_ff == KIND_END) begin
               if (!vld_ff || rsp_ready) begin
                  vld_in = 1'b1;
                  out_in.first_bit = lo_ff[CODE_BITS-2];
                  out_in.follow_count = (pend_ff != '1) ? pend_ff + 1'b1 : pend_ff;
                  out_in.last = 1'b1;
                  idx_in = '0; st_in = S_INIT;
               end
            end else begin
               if (vld_ff) out_in.last = 1'b1;
               st_in = S_FIN;
            end
         end
         S_FIN: begin
            st_in = S_IDLE;
         end
         S_LRD: begin
            ra = idx_ff[AW-1:0]; st_in = S_LEND;
         end
         S_LEND: begin
            base_in = rd_ff;
            if (32'(sym_ff) < ALPHABET) begin
               v = ((rd_ff + TW'(cnt_ff)) > LIMIT - 1'b1) ? LIMIT - 1'b1
                   : rd_ff + TW'(cnt_ff);
               acc_in = v; idx_in = idx_ff + 1'b1; st_in = S_LWR;
            end else begin
               e = (cnt_ff == '0) ? (TW+1)'(1) : (TW+1)'(cnt_ff);
               if (rd_ff >= LIMIT) e = (TW+1)'(1);
               else if ((TW+1)'(rd_ff) + e > (TW+1)'(LIMIT)) e = (TW+1)'(LIMIT - rd_ff);
               we = 1'b1; wa = AW'(DEPTH - 1); wd = rd_ff + TW'(e);
               tot_in = rd_ff + TW'(e); st_in = S_IDLE;
            end
         end
         S_LWR: begin
            we = 1'b1;
            if (idx_ff == (AW+1)'(DEPTH - 1)) begin
               wd = acc_ff + 1'b1; tot_in = acc_ff + 1'b1; st_in = S_IDLE;
            end else begin
               wd = acc_ff; idx_in = idx_ff + 1'b1;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in; hi_ff <= hi_in; pend_ff <= pend_in; tot_ff <= tot_in;
      sym_ff <= sym_in; kind_ff <= kind_in; cnt_ff <= cnt_in;
      lob_ff <= lob_in; upb_ff <= upb_in; prev_ff <= prev_in; acc_ff <= acc_in;
      base_ff <= base_in; rng_ff <= rng_in; upq_ff <= upq_in;
      out_ff <= out_in;
      if (reset) begin
         st_ff <= S_INIT; idx_ff <= '0; mode_ff <= 1'b0; vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in; idx_ff <= idx_in; mode_ff <= mode_in; vld_ff <= vld_in;
      end
   end

   logic emit_hold;
   assign emit_hold = 1'b0;

   assign req_ready = (st_ff == S_IDLE) && !emit_hold;
   assign csr_ready = 1'b1;
   // a beat of the current item stays hidden until a further code bit shows it is not last
   assign rsp_valid = vld_ff && !((st_ff == S_EMIT) && !out_ff.last
                      && (hi_ff[CODE_BITS-1] != lo_ff[CODE_BITS-1])
                      && kind_ff != KIND_END);
   assign rsp_data = out_ff;

`ifndef SYNTHESIS
   a_no_req_in_init: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_INIT |-> !req_ready) else $error("ready during table init");
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_EMIT && st_in == S_INIT) |=> vld_ff && out_ff.last)
      else $error("flush beat lost");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff && !rsp_ready |=> vld_ff) else $error("beat dropped");
`endif
endmodule
